FILE: sv/wstpm_pkg.sv
// Package for the wheel speed tire pressure monitor.
// Holds field widths, reset values, register indexes and the pair compare type.
// No dependencies.
`timescale 1ns / 1ps

package wstpm_pkg;

  localparam int SpeedW   = 16;
  localparam int SteerW   = 15;
  localparam int CountLimW = 12;
  localparam int PctW     = 6;
  localparam int CntW     = 16;
  localparam int NumWheels = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [SteerW-1:0]    SteerLimitReset = SteerW'(30);
  localparam logic [CountLimW-1:0] CountLimitReset = CountLimW'(10);
  localparam logic [PctW-1:0]      ThresholdReset  = PctW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEER_LIMIT = 2'd0,
    REG_COUNT_LIMIT = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic above;
    logic below;
  } pair_cmp_t;

endpackage

FILE: sv/wstpm_pair_cmp.sv
// Relative speed difference test for one wheel pair.
// Compares 2*(a-b)/(a+b) against +-pct/100 by exact cross-multiplication.
// Depends on wstpm_pkg.
`timescale 1ns / 1ps

module wstpm_pair_cmp import wstpm_pkg::*; (
  input  logic signed [SpeedW-1:0] speed_a,
  input  logic signed [SpeedW-1:0] speed_b,
  input  logic        [PctW-1:0]   pct,
  output pair_cmp_t                result
);

  localparam int SumW = SpeedW + 1;
  localparam int ProdW = SumW + 8;

  logic signed [SumW-1:0]  diff;
  logic signed [SumW-1:0]  sum;
  logic signed [ProdW-1:0] lhs;
  logic signed [ProdW-1:0] rhs;
  logic signed [ProdW-1:0] rhs_neg;

  assign diff = SumW'(speed_a) - SumW'(speed_b);
  assign sum  = SumW'(speed_a) + SumW'(speed_b);

  // 200 * diff as shift-and-add: 128 + 64 + 8.
  assign lhs = (ProdW'(diff) <<< 7) + (ProdW'(diff) <<< 6) + (ProdW'(diff) <<< 3);
  assign rhs = ProdW'(sum) * $signed({1'b0, pct});
  assign rhs_neg = -rhs;

  // A zero sum makes rhs zero, so the non-negative branch reduces to the sign of diff.
  always_comb begin
    if (sum[SumW-1]) begin
      result.above = lhs < rhs;
      result.below = lhs > rhs_neg;
    end else begin
      result.above = lhs > rhs;
      result.below = lhs < rhs_neg;
    end
  end

endmodule

FILE: sv/wheel_speed_tire_pressure_monitor.sv
// Top level of the indirect tire pressure monitor.
// Instantiates four wstpm_pair_cmp units; depends on wstpm_pkg.
// Takes one wheel speed beat per clock unless the output stalls; one result beat per input.
`timescale 1ns / 1ps

// Each input beat passes an input register that feeds the pair compares, a condition
// register that feeds the four wheel counters, and the result register that holds the
// warnings; a new beat is taken every cycle while the output is not stalled.
// Configuration writes are always taken; the block does not wait until the pipeline has
// drained, so a write applies to beats accepted afterwards and to beats still in flight.

module wheel_speed_tire_pressure_monitor import wstpm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SpeedW-1:0]   speed_front_left,
  input  logic signed [SpeedW-1:0]   speed_front_right,
  input  logic signed [SpeedW-1:0]   speed_rear_left,
  input  logic signed [SpeedW-1:0]   speed_rear_right,
  input  logic signed [SpeedW-1:0]   steering_angle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       warn_front_left,
  output logic                       warn_front_right,
  output logic                       warn_rear_left,
  output logic                       warn_rear_right,
  output logic                       cornering_skip
);

  logic [SteerW-1:0]    steer_limit;
  logic [CountLimW-1:0] count_limit;
  logic [PctW-1:0]      threshold_percent;

  logic                     a_valid;
  logic signed [SpeedW-1:0] a_fl, a_fr, a_rl, a_rr, a_ang;

  logic                 c_valid;
  logic [NumWheels-1:0] c_cond;
  logic                 c_skip;

  logic [CntW-1:0] wheel_cnt      [NumWheels];
  logic [CntW-1:0] wheel_cnt_next [NumWheels];
  logic [CntW-1:0] hold_level;
  logic [NumWheels-1:0] warn_next;

  pair_cmp_t cmp_front, cmp_rear, cmp_left, cmp_right;
  logic [NumWheels-1:0] cond_next;
  logic [SpeedW:0]      steer_mag;
  logic                 skip_next;

  logic adv_out;
  logic c_ready;
  logic adv_c;
  logic in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_limit       <= SteerLimitReset;
      count_limit       <= CountLimitReset;
      threshold_percent <= ThresholdReset;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEER_LIMIT: steer_limit       <= cfg_data[SteerW-1:0];
        REG_COUNT_LIMIT: count_limit       <= cfg_data[CountLimW-1:0];
        REG_THRESHOLD:   threshold_percent <= cfg_data[PctW-1:0];
        default: ;
      endcase
    end
  end

  assign adv_out  = c_valid && (!out_valid || out_ready);
  assign c_ready  = !c_valid || adv_out;
  assign adv_c    = a_valid && c_ready;
  assign in_ready = !a_valid || c_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_fl  <= speed_front_left;
      a_fr  <= speed_front_right;
      a_rl  <= speed_rear_left;
      a_rr  <= speed_rear_right;
      a_ang <= steering_angle;
    end
  end

  wstpm_pair_cmp u_cmp_front (.speed_a(a_fl), .speed_b(a_fr), .pct(threshold_percent),
                              .result(cmp_front));
  wstpm_pair_cmp u_cmp_rear  (.speed_a(a_rl), .speed_b(a_rr), .pct(threshold_percent),
                              .result(cmp_rear));
  wstpm_pair_cmp u_cmp_left  (.speed_a(a_fl), .speed_b(a_rl), .pct(threshold_percent),
                              .result(cmp_left));
  wstpm_pair_cmp u_cmp_right (.speed_a(a_fr), .speed_b(a_rr), .pct(threshold_percent),
                              .result(cmp_right));

  assign cond_next[0] = cmp_front.above && cmp_left.above;
  assign cond_next[1] = cmp_front.below && cmp_right.above;
  assign cond_next[2] = cmp_rear.above  && cmp_left.below;
  assign cond_next[3] = cmp_rear.below  && cmp_right.below;

  assign steer_mag = a_ang[SpeedW-1] ? -(SpeedW+1)'(a_ang) : (SpeedW+1)'(a_ang);
  assign skip_next = steer_mag > (SpeedW+1)'(steer_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_cond <= cond_next;
      c_skip <= skip_next;
    end
  end

  // Ten times the count limit, built from shifts.
  assign hold_level = (CntW'(count_limit) << 3) + (CntW'(count_limit) << 1);

  always_comb begin
    for (int k = 0; k < NumWheels; k++) begin
      wheel_cnt_next[k] = wheel_cnt[k];
      if (!c_skip) begin
        if (c_cond[k]) begin
          if (wheel_cnt[k] != '1) begin
            wheel_cnt_next[k] = wheel_cnt[k] + CntW'(1);
          end
        end else if (wheel_cnt[k] < hold_level && wheel_cnt[k] != '0) begin
          wheel_cnt_next[k] = wheel_cnt[k] - CntW'(1);
        end
      end
      warn_next[k] = wheel_cnt_next[k] > CntW'(count_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumWheels; k++) begin
        wheel_cnt[k] <= '0;
      end
    end else if (adv_out) begin
      for (int k = 0; k < NumWheels; k++) begin
        wheel_cnt[k] <= wheel_cnt_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      warn_front_left  <= warn_next[0];
      warn_front_right <= warn_next[1];
      warn_rear_left   <= warn_next[2];
      warn_rear_right  <= warn_next[3];
      cornering_skip   <= c_skip;
    end
  end

endmodule
